/* rtl/input_channel_owner_arbiter_macros.svh */
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef INPUT_CHANNEL_OWNER_ARBITER_MACROS_SVH
`define INPUT_CHANNEL_OWNER_ARBITER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define ICOA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ICOA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ICOA_ASSERT_NOW(label, ante, cons, msg)
`define ICOA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/icoa_pkg.sv */
package icoa_pkg;

	// default widths
	localparam int TIME_BITS_DEF = 64;
	localparam int MAG_BITS_DEF  = 16;

	// fixed field widths
	localparam int MAG_FIELD_W = 16;
	localparam int REASON_W    = 4;
	localparam int WINDOW_W    = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

	// register reset values
	localparam logic [MAG_FIELD_W-1:0] ENTER_RST   = 16'd32768;
	localparam logic [MAG_FIELD_W-1:0] SUSTAIN_RST = 16'd16384;
	localparam logic [WINDOW_W-1:0]    WINDOW_RST  = 32'd500000;

	// mode codes; any higher code is a global reset
	localparam logic [1:0] MODE_NORMAL    = 2'd0;
	localparam logic [1:0] MODE_PAD_RESET = 2'd1;

	// reason codes
	localparam logic [REASON_W-1:0] REASON_NONE         = 4'd0;
	localparam logic [REASON_W-1:0] REASON_NOT_GAMEPLAY = 4'd1;

	typedef enum logic [1:0] {
		OWNER_NONE = 2'd0,
		OWNER_KM   = 2'd1,
		OWNER_PAD  = 2'd2
	} owner_t;

	// one result beat
	typedef struct packed {
		owner_t              owner;
		logic                gate_pad;
		logic [REASON_W-1:0] reason;
	} result_t;

endpackage

/* rtl/input_channel_owner_arbiter.sv */
// Input channel owner arbiter.
// Input channel (in_valid/in_ready): one beat per event carries the mode,
// gameplay context, keyboard/mouse activity flags and time, current time,
// gamepad magnitude and the two source reason codes.
// Output channel (out_valid/out_ready): exactly one beat per input beat with
// owner, gate_pad and reason, in input order.
// Config channel (cfg_valid/cfg_ready): cfg_index selects enter threshold (0),
// sustain threshold (1) or quiet window (2); other indexes are dropped.
// cfg_ready is always high; write only while no beat is in flight.
// Path: a beat sits in the input register after acceptance and is decided
// into the output register once that register is empty or being read;
// out_valid rises as the beat enters the output register.
// Throughput: one beat per cycle, stalls aside; the owner state updates as a
// beat leaves the input register, so consecutive beats see each other's state.
// Receiver stall: the output register holds its beat, the input register
// fills, and in_ready drops only when both are full.
// Reset: owner none, no gamepad candidate, no activity time, registers back
// to their defaults, both pipeline stages empty.
`include "input_channel_owner_arbiter_macros.svh"
module input_channel_owner_arbiter
	import icoa_pkg::*;
#(
	parameter int TIME_BITS      = TIME_BITS_DEF,
	parameter int MAGNITUDE_BITS = MAG_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// config
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	// input beats
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic                      gameplay_context,
	input  logic                      km_active,
	input  logic                      km_activation,
	input  logic [TIME_BITS-1:0]      km_activity_time,
	input  logic [TIME_BITS-1:0]      now_time,
	input  logic [MAGNITUDE_BITS-1:0] pad_magnitude,
	input  logic [REASON_W-1:0]       km_reason_code,
	input  logic [REASON_W-1:0]       pad_reason_code,
	// result beats
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                owner,
	output logic                      gate_pad,
	output logic [REASON_W-1:0]       reason
);

	// magnitude compares use at most the field width
	localparam int MAG_W = (MAGNITUDE_BITS < MAG_FIELD_W) ? MAGNITUDE_BITS : MAG_FIELD_W;

	// settings
	logic [MAG_FIELD_W-1:0] enter_q;
	logic [MAG_FIELD_W-1:0] sustain_q;
	logic [WINDOW_W-1:0]    window_q;

	// input stage
	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic                 ctx_s1;
	logic                 km_act_s1;
	logic                 km_evt_s1;
	logic [TIME_BITS-1:0] km_time_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [MAG_W-1:0]     mag_s1;
	logic [REASON_W-1:0]  km_reason_s1;
	logic [REASON_W-1:0]  pad_reason_s1;

	// arbitration state
	owner_t               owner_q;
	logic                 cand_q;
	logic [TIME_BITS-1:0] last_q;

	// result stage
	logic    out_valid_q;
	result_t res_q;

	owner_t               owner_nxt;
	logic                 cand_nxt;
	logic [TIME_BITS-1:0] last_nxt;
	result_t              res_nxt;
	logic                 adv;
	logic                 in_take;

	// handshake
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign in_take   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q   <= ENTER_RST;
			sustain_q <= SUSTAIN_RST;
			window_q  <= WINDOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENTER:   enter_q   <= cfg_data[MAG_FIELD_W-1:0];
				CFG_SUSTAIN: sustain_q <= cfg_data[MAG_FIELD_W-1:0];
				CFG_WINDOW:  window_q  <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_take || (valid_s1 && !adv);
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1       <= mode;
			ctx_s1        <= gameplay_context;
			km_act_s1     <= km_active;
			km_evt_s1     <= km_activation;
			km_time_s1    <= km_activity_time;
			now_s1        <= now_time;
			mag_s1        <= pad_magnitude[MAG_W-1:0];
			km_reason_s1  <= km_reason_code;
			pad_reason_s1 <= pad_reason_code;
		end
	end

	icoa_decide #(
		.TIME_BITS (TIME_BITS),
		.MAG_W     (MAG_W)
	) u_decide (
		.mode             (mode_s1),
		.gameplay_context (ctx_s1),
		.km_active        (km_act_s1),
		.km_activation    (km_evt_s1),
		.km_activity_time (km_time_s1),
		.now_time         (now_s1),
		.pad_magnitude    (mag_s1),
		.km_reason_code   (km_reason_s1),
		.pad_reason_code  (pad_reason_s1),
		.enter_thr        (enter_q[MAG_W-1:0]),
		.sustain_thr      (sustain_q[MAG_W-1:0]),
		.quiet_window     (window_q),
		.owner_cur        (owner_q),
		.cand_cur         (cand_q),
		.last_cur         (last_q),
		.owner_nxt        (owner_nxt),
		.cand_nxt         (cand_nxt),
		.last_nxt         (last_nxt),
		.res              (res_nxt)
	);

	// state update as a beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= OWNER_NONE;
			cand_q  <= 1'b0;
			last_q  <= '0;
		end else if (adv) begin
			owner_q <= owner_nxt;
			cand_q  <= cand_nxt;
			last_q  <= last_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else
			out_valid_q <= adv || (out_valid_q && !out_ready);
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nxt;
	end

	assign out_valid = out_valid_q;
	assign owner     = res_q.owner;
	assign gate_pad  = res_q.gate_pad;
	assign reason    = res_q.reason;

	// checks
	`ICOA_ASSERT_NOW(a_km_gates_pad, out_valid_q && res_q.owner == OWNER_KM,
		res_q.gate_pad, "keyboard/mouse owner without gamepad gate")
	`ICOA_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_ready,
		"input stalled with empty output register")
	`ICOA_ASSERT_NEXT(a_global_clear,
		adv && mode_s1 != MODE_NORMAL && mode_s1 != MODE_PAD_RESET,
		owner_q == OWNER_NONE && !cand_q && last_q == '0,
		"global reset beat left state behind")
	`ICOA_ASSERT_NEXT(a_time_monotonic, adv && mode_s1 == MODE_PAD_RESET,
		last_q >= $past(last_q), "activity time went backward")
	`ICOA_ASSERT_NEXT(a_pad_reset_drops_pad, adv && mode_s1 == MODE_PAD_RESET,
		owner_q != OWNER_PAD && !cand_q, "gamepad kept after source reset")

endmodule

/* rtl/icoa_decide.sv */
module icoa_decide
	import icoa_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int MAG_W     = MAG_FIELD_W
) (
	// item
	input  logic [1:0]           mode,
	input  logic                 gameplay_context,
	input  logic                 km_active,
	input  logic                 km_activation,
	input  logic [TIME_BITS-1:0] km_activity_time,
	input  logic [TIME_BITS-1:0] now_time,
	input  logic [MAG_W-1:0]     pad_magnitude,
	input  logic [REASON_W-1:0]  km_reason_code,
	input  logic [REASON_W-1:0]  pad_reason_code,
	// settings
	input  logic [MAG_W-1:0]     enter_thr,
	input  logic [MAG_W-1:0]     sustain_thr,
	input  logic [WINDOW_W-1:0]  quiet_window,
	// current state
	input  owner_t               owner_cur,
	input  logic                 cand_cur,
	input  logic [TIME_BITS-1:0] last_cur,
	// next state and result
	output owner_t               owner_nxt,
	output logic                 cand_nxt,
	output logic [TIME_BITS-1:0] last_nxt,
	output result_t              res
);

	logic                 km_newer;
	logic [TIME_BITS-1:0] last_max;
	logic [TIME_BITS-1:0] diff;
	logic                 now_ge;
	logic                 in_window;
	logic                 at_enter;
	logic                 at_sustain;
	logic                 held;
	logic                 km_any;
	owner_t               own;

	// activity time max and quiet window; both differences run in parallel
	always_comb begin
		km_newer  = km_activity_time > last_cur;
		last_max  = km_newer ? km_activity_time : last_cur;
		diff      = km_newer ? (now_time - km_activity_time) : (now_time - last_cur);
		now_ge    = km_newer ? (now_time >= km_activity_time) : (now_time >= last_cur);
		in_window = (last_max != '0) && now_ge && (diff <= TIME_BITS'(quiet_window));
	end

	assign at_enter   = pad_magnitude >= enter_thr;
	assign at_sustain = pad_magnitude >= sustain_thr;
	assign held       = (owner_cur == OWNER_PAD) || cand_cur;
	assign km_any     = km_active || km_activation;

	// owner decision
	always_comb begin
		owner_nxt = owner_cur;
		cand_nxt  = cand_cur;
		last_nxt  = last_cur;
		res       = '{owner: OWNER_NONE, gate_pad: 1'b0, reason: REASON_NONE};
		own       = owner_cur;
		unique case (mode)
			MODE_NORMAL: begin
				if (!gameplay_context) begin
					owner_nxt  = OWNER_NONE;
					cand_nxt   = 1'b0;
					last_nxt   = '0;
					res.reason = REASON_NOT_GAMEPLAY;
				end else begin
					last_nxt = last_max;
					cand_nxt = at_sustain && (held || at_enter);
					if (km_any || in_window) begin
						own        = OWNER_KM;
						res.reason = km_reason_code;
					end else if ((held && at_sustain) || at_enter) begin
						own        = OWNER_PAD;
						res.reason = pad_reason_code;
					end else begin
						own        = OWNER_NONE;
						res.reason = REASON_NONE;
					end
					owner_nxt    = own;
					res.owner    = own;
					res.gate_pad = (own != OWNER_PAD);
				end
			end
			MODE_PAD_RESET: begin
				cand_nxt = 1'b0;
				last_nxt = last_max;
				if (km_any) begin
					own        = OWNER_KM;
					res.reason = km_reason_code;
				end
				if (own == OWNER_PAD)
					own = OWNER_NONE;
				owner_nxt    = own;
				res.owner    = own;
				res.gate_pad = 1'b1;
			end
			default: begin
				// global reset
				owner_nxt = OWNER_NONE;
				cand_nxt  = 1'b0;
				last_nxt  = '0;
			end
		endcase
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import icoa_pkg::*;

	localparam logic [1:0] MODE_GLOBAL_RESET = 2'd2;
	localparam logic [1:0] MODE_SPARE        = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int GAP_NONE  = 0;
	localparam int GAP_SOME  = 1;
	localparam int GAP_HEAVY = 2;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRESSURE_HOLD  = 150;
	localparam int TB = TIME_BITS_DEF;

	// one input event as it crosses the input channel
	typedef struct packed {
		logic [1:0]             mode;
		logic                   ctx;
		logic                   act;
		logic                   evt;
		logic [TB-1:0]          km_time;
		logic [TB-1:0]          now;
		logic [MAG_FIELD_W-1:0] mag;
		logic [REASON_W-1:0]    km_rsn;
		logic [REASON_W-1:0]    pad_rsn;
	} arb_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             mode = '0;
	logic                   gameplay_context = 1'b0;
	logic                   km_active = 1'b0;
	logic                   km_activation = 1'b0;
	logic [TB-1:0]          km_activity_time = '0;
	logic [TB-1:0]          now_time = '0;
	logic [MAG_FIELD_W-1:0] pad_magnitude = '0;
	logic [REASON_W-1:0]    km_reason_code = '0;
	logic [REASON_W-1:0]    pad_reason_code = '0;

	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [1:0]             owner;
	logic                   gate_pad;
	logic [REASON_W-1:0]    reason;

	input_channel_owner_arbiter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.gameplay_context (gameplay_context),
		.km_active        (km_active),
		.km_activation    (km_activation),
		.km_activity_time (km_activity_time),
		.now_time         (now_time),
		.pad_magnitude    (pad_magnitude),
		.km_reason_code   (km_reason_code),
		.pad_reason_code  (pad_reason_code),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.owner            (owner),
		.gate_pad         (gate_pad),
		.reason           (reason)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// shadow registers and arbitration state of the predictor
	logic [MAG_FIELD_W-1:0] enter_lvl   = ENTER_RST;
	logic [MAG_FIELD_W-1:0] sustain_lvl = SUSTAIN_RST;
	logic [WINDOW_W-1:0]    quiet_us    = WINDOW_RST;
	owner_t                 held_owner  = OWNER_NONE;
	logic                   pad_cand    = 1'b0;
	logic [TB-1:0]          km_latest   = '0;

	arb_event_t arb_events[$];
	result_t    owner_verdicts[$];
	int         events_queued = 0;
	int         verdicts_checked = 0;
	int         fail_count = 0;
	int         gap_style = GAP_SOME;

	// timeline used to build plausible event sequences
	logic [TB-1:0] story_us;
	logic [TB-1:0] story_km_us;

	// predicted ownership decision for one event; updates the predictor state
	function automatic result_t decide_owner(input arb_event_t b);
		result_t r;
		logic [TB-1:0] last;
		logic at_enter, at_sustain, held, in_win;
		r.owner = OWNER_NONE;
		r.gate_pad = 1'b0;
		r.reason = REASON_NONE;
		if (b.mode == MODE_GLOBAL_RESET || b.mode == MODE_SPARE) begin
			held_owner = OWNER_NONE;
			pad_cand = 1'b0;
			km_latest = '0;
		end else if (b.mode == MODE_PAD_RESET) begin
			// gameplay context plays no part here
			pad_cand = 1'b0;
			if (b.km_time > km_latest)
				km_latest = b.km_time;
			if (b.act || b.evt) begin
				held_owner = OWNER_KM;
				r.reason = b.km_rsn;
			end
			if (held_owner == OWNER_PAD)
				held_owner = OWNER_NONE;
			r.owner = held_owner;
			r.gate_pad = 1'b1;
		end else if (!b.ctx) begin
			held_owner = OWNER_NONE;
			pad_cand = 1'b0;
			km_latest = '0;
			r.reason = REASON_NOT_GAMEPLAY;
		end else begin
			last = (b.km_time > km_latest) ? b.km_time : km_latest;
			at_enter = (b.mag >= enter_lvl);
			at_sustain = (b.mag >= sustain_lvl);
			held = (held_owner == OWNER_PAD) || pad_cand;
			km_latest = last;
			pad_cand = at_sustain && (held || at_enter);
			// quiet window only counts once activity was seen and time moved forward
			in_win = (last != '0) && (b.now >= last) &&
				((b.now - last) <= {{(TB-WINDOW_W){1'b0}}, quiet_us});
			if (b.act || b.evt || in_win) begin
				held_owner = OWNER_KM;
				r.reason = b.km_rsn;
				r.gate_pad = 1'b1;
			end else begin
				if ((held && at_sustain) || at_enter) begin
					held_owner = OWNER_PAD;
					r.reason = b.pad_rsn;
				end else begin
					held_owner = OWNER_NONE;
					r.reason = REASON_NONE;
				end
				r.gate_pad = (held_owner != OWNER_PAD);
			end
			r.owner = held_owner;
		end
		return r;
	endfunction

	function automatic int draw_gap();
		if (gap_style == GAP_NONE)
			return 0;
		if (gap_style == GAP_SOME && $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	// input driver
	int         in_wait = 0;
	arb_event_t bus_event;
	arb_event_t next_event;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_wait <= 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				bus_event = {mode, gameplay_context, km_active, km_activation,
					km_activity_time, now_time, pad_magnitude, km_reason_code,
					pad_reason_code};
				owner_verdicts.push_back(decide_owner(bus_event));
			end
			if (in_wait != 0) begin
				in_wait <= in_wait - 1;
				in_valid <= 1'b0;
			end else if (arb_events.size() != 0) begin
				next_event = arb_events.pop_front();
				mode <= next_event.mode;
				gameplay_context <= next_event.ctx;
				km_active <= next_event.act;
				km_activation <= next_event.evt;
				km_activity_time <= next_event.km_time;
				now_time <= next_event.now;
				pad_magnitude <= next_event.mag;
				km_reason_code <= next_event.km_rsn;
				pad_reason_code <= next_event.pad_rsn;
				in_valid <= 1'b1;
				in_wait <= draw_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver back-pressure
	int      out_wait = 0;
	int      hold_left = 0;
	int      rx_gap;
	logic    pressure_done = 1'b0;
	result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
			hold_left <= 0;
		end else if (out_valid && out_ready) begin
			if (owner_verdicts.size() == 0) begin
				if (fail_count < 10)
					$display("result beat owner=%0d gate_pad=%0b reason=%0d with nothing pending",
						owner, gate_pad, reason);
				fail_count++;
			end else begin
				want = owner_verdicts.pop_front();
				if (owner !== want.owner || gate_pad !== want.gate_pad ||
						reason !== want.reason) begin
					if (fail_count < 10)
						$display("result %0d: expected owner=%0d gate_pad=%0b reason=%0d, got owner=%0d gate_pad=%0b reason=%0d",
							verdicts_checked, want.owner, want.gate_pad, want.reason,
							owner, gate_pad, reason);
					fail_count++;
				end
				verdicts_checked++;
			end
			// one long hold-off while the sender runs flat out, so the pipe backs up
			if (!pressure_done && gap_style == GAP_NONE) begin
				pressure_done <= 1'b1;
				hold_left <= PRESSURE_HOLD;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 63) == 0) begin
				hold_left <= 40;
				out_ready <= 1'b0;
			end else begin
				rx_gap = draw_gap();
				out_wait <= rx_gap;
				out_ready <= (rx_gap == 0);
			end
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= (hold_left == 1);
		end else if (out_wait != 0) begin
			out_wait <= out_wait - 1;
			out_ready <= (out_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog on cycles with no handshake on any channel
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic queue_event(input arb_event_t b);
		arb_events.push_back(b);
		events_queued++;
	endtask

	task automatic add_directed(input logic [1:0] md, input logic ctx, input logic act,
			input logic evt, input logic [TB-1:0] kt, input logic [TB-1:0] nw,
			input logic [MAG_FIELD_W-1:0] mg);
		arb_event_t b;
		b.mode = md;
		b.ctx = ctx;
		b.act = act;
		b.evt = evt;
		b.km_time = kt;
		b.now = nw;
		b.mag = mg;
		b.km_rsn = REASON_W'($urandom_range(0, 15));
		b.pad_rsn = REASON_W'($urandom_range(0, 15));
		queue_event(b);
	endtask

	// well-formed event: time moves on, activity near now, magnitude near thresholds
	task automatic make_story_event(output arb_event_t b);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			b.mode = MODE_PAD_RESET;
		else if (pick < 9)
			b.mode = MODE_GLOBAL_RESET;
		else if (pick < 10)
			b.mode = MODE_SPARE;
		else
			b.mode = MODE_NORMAL;
		b.ctx = ($urandom_range(0, 24) != 0);
		b.act = ($urandom_range(0, 6) == 0);
		b.evt = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 4))
			0: ;
			1: story_us = story_us + TB'($urandom_range(1, 2000));
			2: story_us = story_us + TB'($urandom_range(1, quiet_us));
			// land right at the edge of the quiet window
			3: story_us = story_km_us + TB'(quiet_us) + TB'($urandom_range(0, 2)) - 64'd1;
			default: story_us = story_us + {$urandom_range(0, 255), $urandom};
		endcase
		if (b.act || b.evt || $urandom_range(0, 3) == 0)
			story_km_us = story_us - TB'($urandom_range(0, 50));
		case ($urandom_range(0, 2))
			0: b.km_time = '0;
			1: b.km_time = story_km_us;
			default: b.km_time = story_km_us - TB'($urandom_range(0, 5000));
		endcase
		b.now = story_us;
		case ($urandom_range(0, 7))
			0: b.mag = enter_lvl;
			1: b.mag = enter_lvl - 1'b1;
			2: b.mag = sustain_lvl;
			3: b.mag = sustain_lvl - 1'b1;
			4: b.mag = '1;
			5: b.mag = '0;
			default: b.mag = MAG_FIELD_W'($urandom_range(0, 65535));
		endcase
		b.km_rsn = REASON_W'($urandom_range(0, 15));
		b.pad_rsn = REASON_W'($urandom_range(0, 15));
	endtask

	task automatic run_random(input int count);
		arb_event_t b;
		logic [159:0] raw;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
				b = raw[$bits(arb_event_t)-1:0];
			end else begin
				make_story_event(b);
			end
			queue_event(b);
		end
	endtask

	// wait until every queued event has its result back, then let the pipe settle
	task automatic drain();
		while (verdicts_checked != events_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ENTER:   enter_lvl = val[MAG_FIELD_W-1:0];
			CFG_SUSTAIN: sustain_lvl = val[MAG_FIELD_W-1:0];
			CFG_WINDOW:  quiet_us = val;
			default: ;
		endcase
	endtask

	// stimulus sequence
	initial begin
		story_us = {$urandom_range(0, 255), $urandom};
		story_km_us = story_us;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed sweep at reset settings
		gap_style = GAP_SOME;
		add_directed(MODE_GLOBAL_RESET, 1, 0, 0, 0, 0, 16'hFFFF);
		add_directed(MODE_SPARE, 1, 1, 1, '1, '1, 16'hFFFF);
		add_directed(MODE_NORMAL, 0, 1, 1, 5, 5, 16'hFFFF);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 100, 16'hFFFF);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 200, 16'd20000);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 210, 16'd16384);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 220, 16'd16383);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 230, 16'd20000);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 240, 16'd32768);
		// gamepad source reset drops a gamepad owner, context ignored
		add_directed(MODE_PAD_RESET, 0, 0, 0, 0, 300, 16'hFFFF);
		add_directed(MODE_NORMAL, 1, 1, 0, 0, 400, 16'd0);
		// activation while pad is strong leaves a pad candidate behind
		add_directed(MODE_NORMAL, 1, 0, 1, 0, 500, 16'hFFFF);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 600, 16'd20000);
		// quiet window: zero distance, exact edge, one past
		add_directed(MODE_NORMAL, 1, 0, 0, 1000, 1000, 16'd0);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 501000, 16'd0);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 501001, 16'hFFFF);
		// older time does not lower the running max; now behind last activity
		add_directed(MODE_NORMAL, 1, 0, 0, 5, 999, 16'hFFFF);
		add_directed(MODE_PAD_RESET, 1, 1, 0, 2000, 2100, 16'd0);
		add_directed(MODE_PAD_RESET, 1, 0, 0, 0, 0, 16'd0);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, '1, 16'hFFFF);
		add_directed(MODE_NORMAL, 1, 0, 0, '1, '1, 16'd0);
		add_directed(MODE_NORMAL, 0, 0, 0, 0, 0, 16'd0);
		// after clearing, no activity is known so no window applies
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 5, 16'd0);
		add_directed(MODE_NORMAL, 1, 0, 0, 0, 0, 16'd0);
		drain();

		// extremes: gamepad hard to enter, trivially sustained, zero-length quiet window
		gap_style = GAP_HEAVY;
		write_reg(CFG_ENTER, {16'($urandom), 16'hFFFF});
		write_reg(CFG_SUSTAIN, {16'($urandom), 16'h0000});
		write_reg(CFG_WINDOW, 32'd0);
		write_reg(CFG_UNUSED, $urandom);
		run_random(100);
		drain();

		// opposite extremes
		gap_style = GAP_SOME;
		write_reg(CFG_ENTER, 32'h0000_0000);
		write_reg(CFG_SUSTAIN, 32'hFFFF_FFFF);
		write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
		run_random(80);
		drain();

		// ordinary settings, sender flat out, receiver makes one long hold-off
		gap_style = GAP_NONE;
		write_reg(CFG_SUSTAIN, $urandom_range(1000, 30000));
		write_reg(CFG_ENTER, $urandom_range(30001, 60000));
		write_reg(CFG_WINDOW, $urandom_range(1000, 100000));
		run_random(120);
		drain();

		// equal thresholds, default window
		gap_style = GAP_HEAVY;
		write_reg(CFG_ENTER, 32'd40000);
		write_reg(CFG_SUSTAIN, 32'd40000);
		write_reg(CFG_WINDOW, WINDOW_RST);
		run_random(120);
		drain();

		// anything goes
		gap_style = GAP_SOME;
		write_reg(CFG_ENTER, $urandom);
		write_reg(CFG_SUSTAIN, $urandom);
		write_reg(CFG_WINDOW, $urandom);
		run_random(80);
		drain();

		repeat (8) @(posedge clk);
		if (fail_count == 0 && owner_verdicts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/icoa_pkg.sv
rtl/icoa_decide.sv
rtl/input_channel_owner_arbiter.sv
verif/tb_top.sv
